>>> design/swo_pkg.sv
// ----------------------------------------------------------------------------
// swo_pkg
// shared types, constants and a distance function for the seek-wait request ordering block
// ----------------------------------------------------------------------------
package swo_pkg;

    localparam int POS_W  = 16;
    localparam int COST_W = 32;
    localparam int IDX_W  = 5;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DIAG,
        ST_RD_POS,
        ST_WT_POS,
        ST_RD_TAB,
        ST_WT_TAB,
        ST_CALC,
        ST_WR,
        ST_OUT_RD,
        ST_OUT_WT,
        ST_OUT_CALC
    } state_t;

    function automatic logic [POS_W-1:0] dist16(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
        dist16 = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

>>> design/swo_ram.sv
// ----------------------------------------------------------------------------
// swo_ram
// generic single-port-write, two-port-read ram with registered read data
// ----------------------------------------------------------------------------
module swo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 528
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

>>> design/seek_wait_optimal_order_dp.sv
// ----------------------------------------------------------------------------
// seek_wait_optimal_order_dp
// optimal service order of a request batch by interval dynamic programming
// ----------------------------------------------------------------------------
// Requests are taken one per cycle while busy is low; the head position is
// sampled with the first request of a batch. The request with last_request
// high starts the table fill: one diagonal entry per request, then each
// of the N*(N-1)/2 triangle cells is read, computed and written, and each
// result is read and compared before it is emitted. Results come one per
// strobe and cannot be stalled. The sequencer sets a cell's cost from three
// memories with registered reads: request store, left and right cost tables.
module seek_wait_optimal_order_dp #(
    parameter int MAX_REQUESTS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [15:0]             request_position,
    input  logic [15:0]             head_position,
    input  logic                    last_request,
    output logic                    strobe,
    output logic [15:0]             served_position,
    output logic [4:0]              order_index,
    output logic                    last_of_order
);
    import swo_pkg::*;

    localparam int N_W   = $clog2(MAX_REQUESTS + 1);
    localparam int A_W   = $clog2(MAX_REQUESTS);
    localparam int DEPTH = MAX_REQUESTS * (MAX_REQUESTS + 1) / 2;
    localparam int T_W   = $clog2(DEPTH);

    state_t state_reg, state_next;
    logic [N_W-1:0] cnt_reg, cnt_next;
    logic [15:0] head_reg, head_next;
    logic [A_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [N_W-1:0] len_reg, len_next;
    logic [N_W-1:0] k_reg, k_next;
    logic [POS_W-1:0] pi_reg, pi1_reg, pj_reg, pj1_reg;
    logic [COST_W-1:0] lt_reg, rt_reg, lb_reg, rb_reg;

    logic p_we;
    logic [A_W-1:0] p_wa, p_ra, p_rb;
    logic [POS_W-1:0] p_da, p_db;
    logic t_we;
    logic [T_W-1:0] t_wa, t_ra, t_rb;
    logic [COST_W-1:0] l_wd, r_wd, l_da, l_db, r_da, r_db;
    logic pos_phase_reg, pos_phase_next;

    swo_ram #(.WIDTH(POS_W), .DEPTH(MAX_REQUESTS)) u_pos (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(request_position),
        .raddr_a(p_ra), .raddr_b(p_rb), .rdata_a(p_da), .rdata_b(p_db));
    swo_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_left (
        .clk(clk), .we(t_we), .waddr(t_wa), .wdata(l_wd),
        .raddr_a(t_ra), .raddr_b(t_rb), .rdata_a(l_da), .rdata_b(l_db));
    swo_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_right (
        .clk(clk), .we(t_we), .waddr(t_wa), .wdata(r_wd),
        .raddr_a(t_ra), .raddr_b(t_rb), .rdata_a(r_da), .rdata_b(r_db));

    function automatic logic [T_W-1:0] tri_idx(input logic [A_W-1:0] a,
                                              input logic [A_W-1:0] b);
        logic [2*A_W+1:0] t;
        t = ({{(A_W+2){1'b0}}, b} * ({{(A_W+2){1'b0}}, b} + 1'b1)) >> 1;
        tri_idx = T_W'(t + a);
    endfunction

    logic [A_W-1:0] n1;
    logic [COST_W-1:0] lenw, remw;
    logic [COST_W-1:0] ca, cb, cc, ce, span, cl, cr;
    logic take_load;

    assign n1 = A_W'(cnt_reg - 1'b1);
    assign take_load = start && !busy;
    assign busy = (state_reg != ST_LOAD);
    assign lenw = COST_W'(len_reg);
    assign remw = COST_W'(cnt_reg - k_reg);

    always_comb
    begin
        span = lenw * COST_W'(dist16(pi_reg, pj_reg));
        ca = lenw * COST_W'(dist16(pi_reg, pi1_reg)) + lt_reg;
        cb = span + rt_reg;
        cc = lenw * COST_W'(dist16(pj_reg, pj1_reg)) + rb_reg;
        ce = span + lb_reg;
        cl = remw * COST_W'(dist16(head_reg, pi_reg)) + lt_reg;
        cr = remw * COST_W'(dist16(head_reg, pj_reg)) + rt_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
                if (take_load && last_request)
                    state_next = ST_DIAG;
            ST_DIAG:
                if (i_reg == n1)
                    state_next = (cnt_reg > 1) ? ST_RD_POS : ST_OUT_RD;
            ST_RD_POS:   state_next = ST_WT_POS;
            ST_WT_POS:   state_next = pos_phase_reg ? ST_RD_TAB : ST_RD_POS;
            ST_RD_TAB:   state_next = ST_WT_TAB;
            ST_WT_TAB:   state_next = ST_CALC;
            ST_CALC:     state_next = ST_WR;
            ST_WR:
                if (N_W'(j_reg) == N_W'(n1) && len_reg == N_W'(n1))
                    state_next = ST_OUT_RD;
                else
                    state_next = ST_RD_POS;
            ST_OUT_RD:   state_next = ST_OUT_WT;
            ST_OUT_WT:   state_next = ST_OUT_CALC;
            ST_OUT_CALC:
                if (k_reg == cnt_reg - 1'b1)
                    state_next = ST_LOAD;
                else
                    state_next = ST_OUT_RD;
            default:     state_next = ST_LOAD;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        cnt_next = cnt_reg;
        head_next = head_reg;
        i_next = i_reg;
        j_next = j_reg;
        len_next = len_reg;
        k_next = k_reg;
        pos_phase_next = pos_phase_reg;
        p_we = 1'b0;
        p_wa = cnt_reg[A_W-1:0];
        p_ra = i_reg;
        p_rb = j_reg;
        t_we = 1'b0;
        t_wa = tri_idx(i_reg, j_reg);
        t_ra = tri_idx(i_reg, j_reg);
        t_rb = tri_idx(i_reg, j_reg);
        l_wd = '0;
        r_wd = '0;
        strobe = 1'b0;
        served_position = pi_reg;
        order_index = k_reg[4:0];
        last_of_order = (k_reg == cnt_reg - 1'b1);
        case (state_reg)
            ST_LOAD:
                if (take_load)
                begin
                    if (cnt_reg < N_W'(MAX_REQUESTS))
                    begin
                        p_we = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg == '0)
                            head_next = head_position;
                    end
                    i_next = '0;
                end
            ST_DIAG:
            begin
                t_we = 1'b1;
                t_wa = tri_idx(i_reg, i_reg);
                i_next = i_reg + 1'b1;
                if (i_reg == n1)
                begin
                    i_next = '0;
                    j_next = A_W'(1);
                    len_next = N_W'(1);
                    pos_phase_next = 1'b0;
                    k_next = '0;
                    if (cnt_reg <= 1)
                        j_next = '0;
                end
            end
            ST_RD_POS:
            begin
                p_ra = pos_phase_reg ? A_W'(i_reg + 1'b1) : i_reg;
                p_rb = pos_phase_reg ? A_W'(j_reg - 1'b1) : j_reg;
            end
            ST_WT_POS:
                pos_phase_next = !pos_phase_reg;
            ST_RD_TAB:
            begin
                t_ra = tri_idx(A_W'(i_reg + 1'b1), j_reg);
                t_rb = tri_idx(i_reg, A_W'(j_reg - 1'b1));
            end
            ST_WR:
            begin
                t_we = 1'b1;
                if (len_reg == N_W'(1))
                begin
                    l_wd = COST_W'(dist16(pi_reg, pi1_reg));
                    r_wd = l_wd;
                end
                else
                begin
                    l_wd = (ca < cb) ? ca : cb;
                    r_wd = (cc < ce) ? cc : ce;
                end
                if (N_W'(j_reg) == N_W'(n1))
                begin
                    len_next = len_reg + 1'b1;
                    i_next = '0;
                    j_next = A_W'(len_reg + 1'b1);
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    j_next = j_reg + 1'b1;
                end
                if (N_W'(j_reg) == N_W'(n1) && len_reg == N_W'(n1))
                begin
                    i_next = '0;
                    j_next = n1;
                end
            end
            ST_OUT_RD:
            begin
                p_ra = i_reg;
                p_rb = j_reg;
            end
            ST_OUT_WT:
                ;
            ST_OUT_CALC:
            begin
                strobe = 1'b1;
                if (cl < cr)
                begin
                    served_position = pi_reg;
                    i_next = i_reg + 1'b1;
                    head_next = pi_reg;
                end
                else
                begin
                    served_position = pj_reg;
                    if (j_reg != '0)
                        j_next = j_reg - 1'b1;
                    head_next = pj_reg;
                end
                k_next = k_reg + 1'b1;
                if (last_of_order)
                    cnt_next = '0;
            end
            default:
                ;
        endcase
    end

    // capture memory read data
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WT_POS && !pos_phase_reg)
        begin
            pi_reg <= p_da;
            pj_reg <= p_db;
        end
        if (state_reg == ST_WT_POS && pos_phase_reg)
        begin
            pi1_reg <= p_da;
            pj1_reg <= p_db;
        end
        if (state_reg == ST_WT_TAB)
        begin
            lt_reg <= l_da;
            rt_reg <= r_da;
            lb_reg <= l_db;
            rb_reg <= r_db;
        end
        if (state_reg == ST_OUT_WT)
        begin
            pi_reg <= p_da;
            pj_reg <= p_db;
            lt_reg <= l_da;
            rt_reg <= r_da;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg <= '0;
            head_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            len_reg <= '0;
            k_reg <= '0;
            pos_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            head_reg <= head_next;
            i_reg <= i_next;
            j_reg <= j_next;
            len_reg <= len_next;
            k_reg <= k_next;
            pos_phase_reg <= pos_phase_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= N_W'(MAX_REQUESTS))
        else $error("request count beyond store");
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result while idle");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_of_order) |=> !busy)
        else $error("not idle after last result");
endmodule
